### rtl/npc_pkg.sv
package npc_pkg;

   // Vector length and number of active classes
   localparam int FEATURE_COUNT = 64;
   localparam int CLASS_COUNT   = 10;
   localparam int MAX_CLASSES   = 10;

   localparam int CNT_W  = $clog2(FEATURE_COUNT + 1);
   localparam int SUM_W  = 38;
   localparam int IDX_W  = 4;

   // Prototype levels in Q0.14
   localparam logic [13:0] LEVEL_HIGH = 14'd13926;
   localparam logic [13:0] LEVEL_LOW  = 14'd2458;

   localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME  = 32'd16777619;
   localparam logic [31:0] GOLDEN     = 32'h9e3779b9;
   localparam logic [31:0] LCG_MUL    = 32'd1664525;
   localparam logic [31:0] LCG_ADD    = 32'd1013904223;

   typedef struct packed {
      logic signed [15:0] feature_value;
      logic               last_element;
   } req_payload_type;

   typedef struct packed {
      logic [IDX_W-1:0] class_index;
      logic [9:0]       class_onehot;
   } rsp_payload_type;

   // Control for the per-class lanes: stage A (square) and stage B (accumulate)
   typedef struct packed {
      logic       a_valid;
      logic       a_last;
      logic       a_acc;
      logic [4:0] a_pos;
      logic       b_valid;
      logic       b_last;
      logic       b_acc;
   } lane_ctrl_type;

   // Class words, first character in the top byte, padded with zeros
   function automatic logic [39:0] word_bytes(input int cls);
      logic [39:0] w;
      case (cls)
         0:       w = {"yes", 16'h0};
         1:       w = {"no", 24'h0};
         2:       w = {"up", 24'h0};
         3:       w = {"down", 8'h0};
         4:       w = {"left", 8'h0};
         5:       w = "right";
         6:       w = {"on", 24'h0};
         7:       w = {"off", 16'h0};
         8:       w = {"stop", 8'h0};
         default: w = {"go", 24'h0};
      endcase
      return w;
   endfunction

   // FNV-1a over the class word, then mixed with the class number
   function automatic logic [31:0] initial_seed(input int cls);
      logic [39:0] w;
      logic [31:0] h;
      logic [31:0] c;
      w = word_bytes(cls);
      h = FNV_OFFSET;
      c = 32'(cls);
      for (int i = 0; i < 5; i++) begin
         if (w[39 - 8*i -: 8] != 8'h00) begin
            h = h ^ {24'h0, w[39 - 8*i -: 8]};
            h = h * FNV_PRIME;
         end
      end
      h = h ^ (c * GOLDEN);
      return h;
   endfunction

endpackage

### rtl/npc_lane.sv
module npc_lane import npc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  lane_ctrl_type       ctrl,
   input  logic signed [15:0]  feature,
   input  logic [31:0]         init_seed,
   output logic [SUM_W-1:0]    final_sum
);

   logic [31:0]        seed_ff, seed_in;
   logic [31:0]        sq_ff, sq_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SUM_W-1:0]   fin_ff, fin_in;
   logic [13:0]        level;
   logic signed [16:0] diff;
   logic [15:0]        mag;
   logic [31:0]        lcg_product;
   logic [SUM_W:0]     wide_sum;
   logic [SUM_W-1:0]   sat_sum;

   // Stage A: prototype element, squared difference, seed step
   always_comb begin
      level = seed_ff[ctrl.a_pos] ? LEVEL_HIGH : LEVEL_LOW;
      diff  = $signed({feature[15], feature}) - $signed({3'b000, level});
      mag   = diff[16] ? 16'(-diff) : diff[15:0];
      sq_in = {16'h0, mag} * {16'h0, mag};
      lcg_product = seed_ff * LCG_MUL;
      seed_in = seed_ff;
      if (ctrl.a_valid) begin
         if (ctrl.a_last) begin
            seed_in = init_seed;
         end else if (ctrl.a_acc) begin
            seed_in = lcg_product + LCG_ADD;
         end
      end
   end

   // Stage B: saturating accumulate; the closing element snapshots the sum
   always_comb begin
      wide_sum = {1'b0, sum_ff} + {{(SUM_W-31){1'b0}}, sq_ff};
      sat_sum  = wide_sum[SUM_W] ? {SUM_W{1'b1}} : wide_sum[SUM_W-1:0];
      sum_in   = sum_ff;
      fin_in   = fin_ff;
      if (ctrl.b_valid) begin
         if (ctrl.b_last) begin
            fin_in = ctrl.b_acc ? sat_sum : sum_ff;
            sum_in = '0;
         end else if (ctrl.b_acc) begin
            sum_in = sat_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= init_seed;
         sum_ff  <= '0;
      end else begin
         seed_ff <= seed_in;
         sum_ff  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff  <= sq_in;
      fin_ff <= fin_in;
   end

   assign final_sum = fin_ff;

endmodule

### rtl/nearest_prototype_classifier_core.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_payload_type (feature_value, last_element)
// rsp       out        rsp_valid/rsp_ready    rsp_payload_type (class_index, class_onehot)
//
// One element is accepted per cycle while req_ready is high. A result passes
// input reg, square, accumulate, pair compare and final compare into the
// result queue after its last element is accepted.
// Reset (synchronous) loads the class seeds and clears sums and counters.
// Results queue in an 8-entry buffer; req_ready drops only while 8 results
// are owed (queued or still in the pipeline).
module nearest_prototype_classifier_core import npc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam int QDEPTH = 8;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);
   localparam int CAND_W = SUM_W + 1;

   logic                req_fire, rsp_fire;

   // stage A: input register
   logic                a_valid_ff, a_last_ff;
   logic signed [15:0]  a_x_ff;
   logic                a_acc;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [4:0]          pos_ff, pos_in;

   // stage B: squares held in lanes
   logic                b_valid_ff, b_last_ff, b_acc_ff;

   // stage C: final sums held in lanes
   logic                c_valid_ff;

   // stage D: pair winners
   logic                d_valid_ff;
   logic [CAND_W-1:0]   pair_val_ff [5];
   logic [IDX_W-1:0]    pair_idx_ff [5];

   lane_ctrl_type       lane_ctrl;
   logic [SUM_W-1:0]    fin_sum [MAX_CLASSES];
   logic [CAND_W-1:0]   cand    [MAX_CLASSES];

   // result queue and owed-result count
   logic [IDX_W-1:0]    q_mem [QDEPTH];
   logic [QPTR_W-1:0]   q_wr_ff, q_rd_ff;
   logic [QCNT_W-1:0]   q_cnt_ff;
   logic [QCNT_W-1:0]   owed_ff;
   logic [IDX_W-1:0]    win_idx;

   assign req_ready = (owed_ff < QCNT_W'(QDEPTH));
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (q_cnt_ff != '0);
   assign rsp_fire  = rsp_valid && rsp_ready;

   // ---------------------------------------------------------------
   // Element counting. Elements past FEATURE_COUNT add nothing and
   // leave the seeds alone; the last mark always closes the vector.
   // ---------------------------------------------------------------
   assign a_acc = a_valid_ff && (count_ff < CNT_W'(FEATURE_COUNT));

   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      if (a_valid_ff) begin
         if (a_last_ff) begin
            count_in = '0;
            pos_in   = '0;
         end else if (a_acc) begin
            count_in = count_ff + 1'b1;
            pos_in   = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         a_last_ff  <= 1'b0;
         b_valid_ff <= 1'b0;
         b_last_ff  <= 1'b0;
         b_acc_ff   <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         count_ff   <= '0;
         pos_ff     <= '0;
      end else begin
         a_valid_ff <= req_fire;
         a_last_ff  <= req_payload.last_element;
         b_valid_ff <= a_valid_ff;
         b_last_ff  <= a_last_ff;
         b_acc_ff   <= a_acc;
         c_valid_ff <= b_valid_ff && b_last_ff;
         d_valid_ff <= c_valid_ff;
         count_ff   <= count_in;
         pos_ff     <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      a_x_ff <= req_payload.feature_value;
   end

   // ---------------------------------------------------------------
   // Class lanes
   // ---------------------------------------------------------------
   always_comb begin
      lane_ctrl.a_valid = a_valid_ff;
      lane_ctrl.a_last  = a_last_ff;
      lane_ctrl.a_acc   = a_acc;
      lane_ctrl.a_pos   = pos_ff;
      lane_ctrl.b_valid = b_valid_ff;
      lane_ctrl.b_last  = b_last_ff;
      lane_ctrl.b_acc   = b_acc_ff;
   end

   for (genvar c = 0; c < MAX_CLASSES; c++) begin : g_lane
      if (c < CLASS_COUNT) begin : g_used
         npc_lane u_lane (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (lane_ctrl),
            .feature   (a_x_ff),
            .init_seed (initial_seed(c)),
            .final_sum (fin_sum[c])
         );
         assign cand[c] = {1'b0, fin_sum[c]};
      end else begin : g_unused
         // absent class: top flag set so it never wins
         assign fin_sum[c] = '0;
         assign cand[c]    = {1'b1, fin_sum[c]};
      end
   end

   // ---------------------------------------------------------------
   // Nearest class: pairs registered, then three compare levels.
   // The left operand always holds the lower indexes, so a tie keeps it.
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      for (int p = 0; p < 5; p++) begin
         if (cand[2*p+1] < cand[2*p]) begin
            pair_val_ff[p] <= cand[2*p+1];
            pair_idx_ff[p] <= IDX_W'(2*p+1);
         end else begin
            pair_val_ff[p] <= cand[2*p];
            pair_idx_ff[p] <= IDX_W'(2*p);
         end
      end
   end

   always_comb begin
      logic [CAND_W-1:0] x_val, y_val, z_val;
      logic [IDX_W-1:0]  x_idx, y_idx, z_idx;
      x_val = pair_val_ff[0];
      x_idx = pair_idx_ff[0];
      if (pair_val_ff[1] < pair_val_ff[0]) begin
         x_val = pair_val_ff[1];
         x_idx = pair_idx_ff[1];
      end
      y_val = pair_val_ff[2];
      y_idx = pair_idx_ff[2];
      if (pair_val_ff[3] < pair_val_ff[2]) begin
         y_val = pair_val_ff[3];
         y_idx = pair_idx_ff[3];
      end
      z_val = x_val;
      z_idx = x_idx;
      if (y_val < x_val) begin
         z_val = y_val;
         z_idx = y_idx;
      end
      win_idx = z_idx;
      if (pair_val_ff[4] < z_val) begin
         win_idx = pair_idx_ff[4];
      end
   end

   // ---------------------------------------------------------------
   // Result queue. owed_ff counts results from accepted last elements
   // that have not left on rsp, so the queue can never overflow.
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
         owed_ff  <= '0;
      end else begin
         if (d_valid_ff) begin
            q_wr_ff <= q_wr_ff + 1'b1;
         end
         if (rsp_fire) begin
            q_rd_ff <= q_rd_ff + 1'b1;
         end
         q_cnt_ff <= q_cnt_ff + QCNT_W'(d_valid_ff) - QCNT_W'(rsp_fire);
         owed_ff  <= owed_ff + QCNT_W'(req_fire && req_payload.last_element)
                     - QCNT_W'(rsp_fire);
      end
   end

   always_ff @(posedge clock) begin
      if (d_valid_ff) begin
         q_mem[q_wr_ff] <= win_idx;
      end
   end

   always_comb begin
      rsp_payload.class_index  = q_mem[q_rd_ff];
      rsp_payload.class_onehot = 10'b1 << q_mem[q_rd_ff];
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_owed_bound: assert property (@(posedge clock) disable iff (reset)
      owed_ff <= QCNT_W'(QDEPTH))
      else $error("owed result count above queue depth");

   a_queue_within_owed: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= owed_ff)
      else $error("queue holds more results than owed");

   a_onehot_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($onehot(rsp_payload.class_onehot)
                     && rsp_payload.class_index < IDX_W'(CLASS_COUNT)))
      else $error("result class out of range or not one-hot");

   a_vector_restart: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && a_last_ff) |=> (count_ff == '0 && pos_ff == '0))
      else $error("element counter not cleared after last element");

endmodule
